// ===== design/hps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_pkg
// Shared widths, constants, types and point tables of the hexagonal patch
// colour sampler.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int CHANS   = 3;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 8;                 // holds (2r+1)^2 up to 225
  localparam int SUM_W   = CNT_W + PIX_W;     // window sum of one channel
  localparam int COORD_W = 14;                // signed, covers frames to 4096
  localparam int WIN_W   = 4;                 // window step counter, 0..14
  localparam int DY_W    = 21;                // sqrt(3)/2 in Q16 times radius

  localparam int DEF_FRAME_WIDTH   = 256;
  localparam int DEF_FRAME_HEIGHT  = 256;
  localparam int MAX_WINDOW_RADIUS = 7;
  localparam int LAST_POINT        = 6;

  localparam logic [15:0] HALF_SQRT3_Q16 = 16'd56756;
  localparam logic [15:0] Q16_FRAC_MASK  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_SQUARE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SQUARE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SAMPLE_RADIUS = 2'd2;
  localparam logic [1:0] REG_WINDOW_RADIUS = 2'd3;

  typedef logic [CHANS-1:0][SUM_W-1:0] chan_sum_t;
  typedef logic [CHANS-1:0][PIX_W-1:0] chan_pix_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // Horizontal offset of each point in half steps of the sample radius.
  function automatic logic signed [2:0] point_x_half(input logic [2:0] k);
    logic signed [2:0] h;
    case (k)
      3'd1:    h = 3'sd1;
      3'd2:    h = -3'sd1;
      3'd3:    h = -3'sd2;
      3'd4:    h = -3'sd1;
      3'd5:    h = 3'sd1;
      3'd6:    h = 3'sd2;
      default: h = 3'sd0;
    endcase
    return h;
  endfunction

  // Sign of the vertical offset of each point; exactly zero on the axis.
  function automatic logic signed [1:0] point_y_sign(input logic [2:0] k);
    logic signed [1:0] s;
    case (k)
      3'd1, 3'd2: s = 2'sd1;
      3'd4, 3'd5: s = -2'sd1;
      default:    s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/hps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module hps_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 65536
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [DATA_W-1:0]        wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/hps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_div
// Restoring divider, one quotient bit per step, three channel lanes sharing
// one divisor. The quotient is known to fit in one pixel.
// ----------------------------------------------------------------------------
module hps_div (
  input  wire                              clk,
  input  wire  hps_pkg::div_ctl_t          ctl,
  input  wire  [hps_pkg::CNT_W-1:0]        divisor,
  input  wire  hps_pkg::chan_sum_t         dividend,
  output hps_pkg::chan_pix_t               quotient
);
  import hps_pkg::*;

  logic [CHANS-1:0][CNT_W-1:0] rem_r, rem_nxt;
  chan_pix_t                   quo_r, quo_nxt;

  // The upper half of the dividend is below the divisor, so the quotient
  // needs only as many steps as a pixel has bits.
  always_comb begin
    logic [CNT_W:0] trial;
    logic           fits;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int c = 0; c < CHANS; c++) begin
      trial = {rem_r[c], quo_r[c][PIX_W-1]};
      fits  = trial >= {1'b0, divisor};
      if (ctl.load) begin
        rem_nxt[c] = dividend[c][SUM_W-1:PIX_W];
        quo_nxt[c] = dividend[c][PIX_W-1:0];
      end else if (ctl.step) begin
        rem_nxt[c] = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
        quo_nxt[c] = {quo_r[c][PIX_W-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== design/hexagonal_patch_color_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexagonal_patch_color_sampler
// Frame store with a hexagonal seven-point window averager for grid squares.
// ----------------------------------------------------------------------------
// A pixel write (mode 0) goes straight into the frame store and busy never
// rises for it. A sample request (mode 1) keeps busy high while its seven
// points are worked through in turn: a point whose window leaves the frame
// needs no reads, while any other has every window pixel come through the
// single read port of the frame store, one a cycle, and the three means then
// come from a shared divider that yields one quotient bit a cycle. Each
// result is shown for one cycle with out_valid and must be taken then; the
// block has no way of holding a result back. The frame store is not cleared
// by reset and no pixel should be read before it has been written.
// ----------------------------------------------------------------------------
module hexagonal_patch_color_sampler #(
  parameter int FRAME_WIDTH  = hps_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = hps_pkg::DEF_FRAME_HEIGHT
) (
  input  wire        clk,
  input  wire        rst_n,
  // input channel
  input  wire        start,
  output logic       busy,
  input  wire        in_mode,
  input  wire  [7:0] in_pixel_x,
  input  wire  [7:0] in_pixel_y,
  input  wire  [7:0] in_chan0_in,
  input  wire  [7:0] in_chan1_in,
  input  wire  [7:0] in_chan2_in,
  input  wire  [2:0] in_square_row,
  input  wire  [2:0] in_square_col,
  // result channel
  output logic       out_valid,
  output logic [2:0] out_point_index,
  output logic [7:0] out_avg0,
  output logic [7:0] out_avg1,
  output logic [7:0] out_avg2,
  output logic       out_out_of_frame,
  output logic       out_last,
  // configuration
  input  wire        cfg_we,
  input  wire  [1:0] cfg_index,
  input  wire  [5:0] cfg_data
);
  import hps_pkg::*;

  localparam int XW     = $clog2(FRAME_WIDTH);
  localparam int YW     = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W = XW + YW;
  localparam int DATA_W = CHANS * PIX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POINT = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // Configuration registers
  logic [5:0] sq_w_r, sq_h_r;
  logic [4:0] samp_rad_r;
  logic [2:0] win_rad_r;

  // Sequencer state
  logic [2:0] state_r, state_nxt;
  logic [2:0] point_r, point_nxt;
  logic [2:0] div_cnt_r, div_cnt_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Request and window payload
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [COORD_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic [2:0]                rad_r, rad_nxt;
  logic [WIN_W-1:0]          span_r, span_nxt;
  logic [WIN_W-1:0]          wi_r, wi_nxt, wj_r, wj_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [4:0]                dyp_r, dyp_nxt, dyn_r, dyn_nxt;
  chan_sum_t                 sum_r, sum_nxt, acc;

  // Output payload
  logic [2:0] out_point_r, out_point_nxt;
  chan_pix_t  out_avg_r, out_avg_nxt;
  logic       out_off_r, out_off_nxt;
  logic       out_last_r, out_last_nxt;

  logic accept;
  assign busy   = state_r != ST_IDLE;
  assign accept = start && !busy;

  // ---------------- request set-up ----------------
  logic [9:0]      prod_x, prod_y;
  logic [2:0]      rad_sat;
  logic [3:0]      side;
  logic [DY_W-1:0] dy_prod, dy_ceil;

  assign prod_x  = 10'(sq_w_r) * 10'({in_square_row, 1'b1});
  assign prod_y  = 10'(sq_h_r) * 10'({in_square_col, 1'b1});
  assign rad_sat = (5'(win_rad_r) > 5'(MAX_WINDOW_RADIUS)) ?
                   3'(MAX_WINDOW_RADIUS) : win_rad_r;
  assign side    = {rad_sat, 1'b1};
  assign dy_prod = DY_W'(HALF_SQRT3_Q16) * DY_W'(samp_rad_r);
  // A negative offset is floored, so its magnitude rounds upwards.
  assign dy_ceil = dy_prod + DY_W'(Q16_FRAC_MASK);

  // ---------------- point placement ----------------
  logic signed [2:0]         xh;
  logic signed [1:0]         ys;
  logic signed [COORD_W-1:0] xoff, yoff, twox, px, py, rad_c;
  logic signed [COORD_W-1:0] x0c, y0c, x1c, y1c, fw_c, fh_c;
  logic                      off;

  assign xh    = point_x_half(point_r);
  assign ys    = point_y_sign(point_r);
  assign xoff  = COORD_W'(xh) * $signed(COORD_W'(samp_rad_r));
  assign twox  = (cx_r <<< 1) + xoff;
  assign px    = twox >>> 1;
  assign yoff  = (ys > 0) ? $signed(COORD_W'(dyp_r)) :
                 (ys < 0) ? -$signed(COORD_W'(dyn_r)) : '0;
  assign py    = cy_r + yoff;
  assign rad_c = $signed(COORD_W'(rad_r));
  assign x0c   = px - rad_c;
  assign y0c   = py - rad_c;
  assign x1c   = px + rad_c;
  assign y1c   = py + rad_c;
  assign fw_c  = $signed(COORD_W'(FRAME_WIDTH));
  assign fh_c  = $signed(COORD_W'(FRAME_HEIGHT));
  assign off   = x0c[COORD_W-1] || y0c[COORD_W-1] || (x1c >= fw_c) || (y1c >= fh_c);

  // ---------------- frame store ----------------
  logic                      ram_we, rd_en;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;
  logic signed [COORD_W-1:0] rx, ry;
  logic                      wr_inside;

  assign wr_inside = (COORD_W'(in_pixel_x) < COORD_W'(FRAME_WIDTH)) &&
                     (COORD_W'(in_pixel_y) < COORD_W'(FRAME_HEIGHT));
  assign ram_we    = accept && !in_mode && wr_inside;
  assign ram_waddr = {YW'(in_pixel_y), XW'(in_pixel_x)};
  assign ram_wdata = {in_chan2_in, in_chan1_in, in_chan0_in};
  assign rx        = x0_r + $signed(COORD_W'(wi_r));
  assign ry        = y0_r + $signed(COORD_W'(wj_r));
  assign ram_raddr = {ry[YW-1:0], rx[XW-1:0]};

  hps_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (1 << ADDR_W)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- divider ----------------
  div_ctl_t  div_ctl;
  chan_pix_t quo;

  hps_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .divisor  (cnt_r),
    .dividend (acc),
    .quotient (quo)
  );

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      acc[c] = sum_r[c] + SUM_W'(ram_rdata[c*PIX_W +: PIX_W]);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    point_nxt     = point_r;
    div_cnt_nxt   = div_cnt_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    rad_nxt       = rad_r;
    span_nxt      = span_r;
    wi_nxt        = wi_r;
    wj_nxt        = wj_r;
    cnt_nxt       = cnt_r;
    dyp_nxt       = dyp_r;
    dyn_nxt       = dyn_r;
    sum_nxt       = rd_pend_r ? acc : sum_r;
    out_valid_nxt = 1'b0;
    out_point_nxt = out_point_r;
    out_avg_nxt   = out_avg_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    div_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_mode) begin
          cx_nxt    = $signed(COORD_W'(prod_x[9:1]));
          cy_nxt    = $signed(COORD_W'(prod_y[9:1]));
          rad_nxt   = rad_sat;
          span_nxt  = WIN_W'({rad_sat, 1'b0});
          cnt_nxt   = CNT_W'(side) * CNT_W'(side);
          dyp_nxt   = dy_prod[DY_W-1:16];
          dyn_nxt   = dy_ceil[DY_W-1:16];
          point_nxt = '0;
          state_nxt = ST_POINT;
        end
      end
      ST_POINT: begin
        sum_nxt = '0;
        wi_nxt  = '0;
        wj_nxt  = '0;
        x0_nxt  = x0c;
        y0_nxt  = y0c;
        if (off) begin
          // No read at all: the result goes out with zero means.
          out_valid_nxt = 1'b1;
          out_point_nxt = point_r;
          out_avg_nxt   = '0;
          out_off_nxt   = 1'b1;
          out_last_nxt  = point_r == 3'(LAST_POINT);
          if (point_r == 3'(LAST_POINT)) begin
            state_nxt = ST_IDLE;
          end else begin
            point_nxt = point_r + 3'd1;
          end
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (wi_r == span_r) begin
          wi_nxt = '0;
          if (wj_r == span_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            wj_nxt = wj_r + WIN_W'(1);
          end
        end else begin
          wi_nxt = wi_r + WIN_W'(1);
        end
      end
      ST_DRAIN: begin
        // The last pixel arrives now and goes straight into the divider.
        div_ctl.load = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 3'd1;
        if (div_cnt_r == 3'(PIX_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_point_nxt = point_r;
        out_avg_nxt   = quo;
        out_off_nxt   = 1'b0;
        out_last_nxt  = point_r == 3'(LAST_POINT);
        if (point_r == 3'(LAST_POINT)) begin
          state_nxt = ST_IDLE;
        end else begin
          point_nxt = point_r + 3'd1;
          state_nxt = ST_POINT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_pend_nxt = rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      point_r     <= '0;
      div_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      sq_w_r      <= 6'd32;
      sq_h_r      <= 6'd32;
      samp_rad_r  <= 5'd8;
      win_rad_r   <= 3'd2;
    end else begin
      state_r     <= state_nxt;
      point_r     <= point_nxt;
      div_cnt_r   <= div_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SQUARE_WIDTH:  sq_w_r     <= cfg_data;
          REG_SQUARE_HEIGHT: sq_h_r     <= cfg_data;
          REG_SAMPLE_RADIUS: samp_rad_r <= cfg_data[4:0];
          REG_WINDOW_RADIUS: win_rad_r  <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    x0_r        <= x0_nxt;
    y0_r        <= y0_nxt;
    rad_r       <= rad_nxt;
    span_r      <= span_nxt;
    wi_r        <= wi_nxt;
    wj_r        <= wj_nxt;
    cnt_r       <= cnt_nxt;
    dyp_r       <= dyp_nxt;
    dyn_r       <= dyn_nxt;
    sum_r       <= sum_nxt;
    out_point_r <= out_point_nxt;
    out_avg_r   <= out_avg_nxt;
    out_off_r   <= out_off_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_point_index  = out_point_r;
  assign out_avg0         = out_avg_r[0];
  assign out_avg1         = out_avg_r[1];
  assign out_avg2         = out_avg_r[2];
  assign out_out_of_frame = out_off_r;
  assign out_last         = out_last_r;

  // ---------------- assertions ----------------
  // A result transfer only ever follows a point that was placed or divided.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_POINT || $past(state_r) == ST_EMIT))
    else $error("result strobe without a finished point");

  // The frame store is never written while a request is being worked on.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("frame store written while busy");

  // Read data only arrives while the window is being swept or drained.
  a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_READ || state_r == ST_DRAIN))
    else $error("frame read data outside a window sweep");

  // A window outside the frame must report zero means.
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_off_r) |-> (out_avg_r == '0))
    else $error("out-of-frame result with non-zero means");

  // The divider finishes its steps before the result is taken from it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ($past(state_r) == ST_DIV && $past(div_cnt_r) == 3'(PIX_W - 1)))
    else $error("result taken from an unfinished division");

endmodule
`default_nettype wire
